@@ rtl/b64e_pkg.sv @@
// Shared types, character codes and the symbol-to-character mapping for the base64 encoder.
package b64e_pkg;

	localparam int unsigned CharW  = 7;
	localparam int unsigned SymW   = 6;
	localparam int unsigned ByteW  = 8;
	localparam int unsigned NChars = 4;

	localparam logic [CharW-1:0] ChDigit0 = 7'd48;  // '0'
	localparam logic [CharW-1:0] ChLowerA = 7'd97;  // 'a'
	localparam logic [CharW-1:0] ChUpperA = 7'd65;  // 'A'
	localparam logic [CharW-1:0] ChBang   = 7'd33;  // '!'
	localparam logic [CharW-1:0] ChDollar = 7'd36;  // '$'
	localparam logic [CharW-1:0] ChPad    = 7'd61;  // '='

	// one encoded group: four characters, first one in element 0
	typedef struct packed {
		logic [NChars-1:0][CharW-1:0] chars;
		logic                         last;
	} grp_t;

	// map a 6-bit symbol to its character: digits, lower case, upper case, '!', '$'
	function automatic logic [CharW-1:0] sym_char(input logic [SymW-1:0] v);
		logic [CharW-1:0] v7;
		logic [CharW-1:0] ch;
		v7 = {1'b0, v};
		if (v < 6'd10) begin
			ch = ChDigit0 + v7;
		end else if (v < 6'd36) begin
			ch = ChLowerA + v7 - 7'd10;
		end else if (v < 6'd62) begin
			ch = ChUpperA + v7 - 7'd36;
		end else if (v == 6'd62) begin
			ch = ChBang;
		end else begin
			ch = ChDollar;
		end
		return ch;
	endfunction

endpackage

@@ rtl/b64e_group.sv @@
// Input register, pending byte store and group encoding for the base64 encoder.
module b64e_group (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,   // [7:0] data_byte
	input  logic                s_tlast,   // end_of_message
	output logic                grp_valid,
	input  logic                grp_ready,
	output b64e_pkg::grp_t      grp
);

	logic                         vld_s1;
	logic [b64e_pkg::ByteW-1:0]   byte_s1;
	logic                         eom_s1;

	logic [1:0][b64e_pkg::ByteW-1:0] held_q;
	logic [1:0]                      count_q;

	logic                         full;
	logic                         emit;
	logic                         adv;
	logic [b64e_pkg::ByteW-1:0]   b0;
	logic [b64e_pkg::ByteW-1:0]   b1;
	logic [b64e_pkg::SymW-1:0]    sym0;
	logic [b64e_pkg::SymW-1:0]    sym1;
	logic [b64e_pkg::SymW-1:0]    sym2;
	logic [b64e_pkg::SymW-1:0]    sym3;

	// a count of three cannot arise; treat it like two
	assign full = count_q[1];
	assign emit = full || eom_s1;
	assign adv  = vld_s1 && (!emit || grp_ready);

	assign s_tready  = !vld_s1 || adv;
	assign grp_valid = vld_s1 && emit;

	always_comb begin
		b0 = held_q[0];
		b1 = held_q[1];
		if (!full && count_q == 2'd0) begin
			b0 = byte_s1;
		end
		if (!full && count_q == 2'd1) begin
			b1 = byte_s1;
		end
		sym0 = b0[7:2];
		sym1 = {b0[1:0], b1[7:4]};
		sym2 = {b1[3:0], byte_s1[7:6]};
		sym3 = byte_s1[5:0];

		grp.chars[0] = b64e_pkg::sym_char(sym0);
		grp.chars[1] = b64e_pkg::sym_char(sym1);
		grp.chars[2] = b64e_pkg::sym_char(sym2);
		grp.chars[3] = b64e_pkg::sym_char(sym3);
		grp.last     = eom_s1;
		if (!full) begin
			grp.chars[3] = b64e_pkg::ChPad;
			if (count_q == 2'd0) begin
				grp.chars[1] = b64e_pkg::sym_char({b0[1:0], 4'd0});
				grp.chars[2] = b64e_pkg::ChPad;
			end else begin
				grp.chars[2] = b64e_pkg::sym_char({b1[3:0], 2'd0});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (s_tready) begin
				vld_s1 <= s_tvalid;
			end
			if (adv) begin
				if (emit) begin
					count_q <= 2'd0;
				end else begin
					count_q <= count_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eom_s1  <= s_tlast;
		end
		// store the byte in its slot while the group stays open
		if (adv && !full) begin
			held_q[count_q[0]] <= byte_s1;
		end
	end

endmodule

@@ rtl/b64e_serial.sv @@
// Group buffer and output register that send one encoded character per beat.
module b64e_serial (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                grp_valid,
	output logic                grp_ready,
	input  b64e_pkg::grp_t      grp,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,   // [6:0] out_char, [7] zero fill
	output logic                m_tlast    // last_char
);

	b64e_pkg::grp_t               buf_q;
	logic                         buf_vld_q;
	logic [1:0]                   idx_q;
	logic                         out_vld_q;
	logic [b64e_pkg::CharW-1:0]   out_char_q;
	logic                         out_last_q;

	logic out_free;
	logic move;
	logic at_end;

	assign out_free  = !out_vld_q || m_tready;
	assign move      = out_free && buf_vld_q;
	assign at_end    = idx_q == 2'd3;
	assign grp_ready = !buf_vld_q || (move && at_end);

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, out_char_q};
	assign m_tlast  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_vld_q <= 1'b0;
			idx_q     <= 2'd0;
			out_vld_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_vld_q <= buf_vld_q;
			end
			if (grp_valid && grp_ready) begin
				buf_vld_q <= 1'b1;
				idx_q     <= 2'd0;
			end else if (move) begin
				idx_q <= idx_q + 2'd1;
				if (at_end) begin
					buf_vld_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (grp_valid && grp_ready) begin
			buf_q <= grp;
		end
		if (move) begin
			out_char_q <= buf_q.chars[idx_q];
			out_last_q <= buf_q.last && at_end;
		end
	end

endmodule

@@ rtl/base64_encode_custom_alphabet_top.sv @@
// Base64 encoder, custom alphabet: bytes in, one character per beat out.
// Path: a closed group passes the input register, the group buffer, then the output register.
// Throughput: one byte per cycle in unless a closed group waits; one character per cycle out
// while m_tready is high, so a steady stream settles at four characters per three bytes.
// Reset: arst_n clears the input register, pending byte count and output buffer at once.
module base64_encode_custom_alphabet_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,   // end_of_message
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero fill
	output logic       m_tlast    // last_char
);

	logic           grp_valid;
	logic           grp_ready;
	b64e_pkg::grp_t grp;

	b64e_group u_group (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.grp_valid (grp_valid),
		.grp_ready (grp_ready),
		.grp       (grp)
	);

	b64e_serial u_serial (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp_valid (grp_valid),
		.grp_ready (grp_ready),
		.grp       (grp),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
